// ===== sv/rfse_pkg.sv =====
// Shared constants, record descriptor type and helpers for the field size encoder.
package rfse_pkg;

  localparam int unsigned DEF_MAX_FIELDS = 16;
  localparam int unsigned VAL_W          = 64;
  localparam int unsigned CODE_W         = 2;
  localparam int unsigned CNT_W          = 5;   // holds up to 31 fields
  localparam int unsigned BYTES_W        = 4;
  localparam int unsigned ENTRY_W        = VAL_W + CODE_W;

  localparam logic [CODE_W-1:0] CODE_1B = 2'd0;
  localparam logic [CODE_W-1:0] CODE_2B = 2'd1;
  localparam logic [CODE_W-1:0] CODE_4B = 2'd2;
  localparam logic [CODE_W-1:0] CODE_8B = 2'd3;

  // descriptor of one finished record, handed from front to back
  typedef struct packed {
    logic              bank;
    logic [CNT_W-1:0]  count;
    logic              trunc;
    logic [VAL_W-1:0]  mask;
  } rec_t;

  function automatic logic [CODE_W-1:0] pick_code(input logic [VAL_W-1:0] v);
    logic [CODE_W-1:0] c;
    if (v[63:32] != '0) begin
      c = CODE_8B;
    end else if (v[31:16] != '0) begin
      c = CODE_4B;
    end else if (v[15:8] != '0) begin
      c = CODE_2B;
    end else begin
      c = CODE_1B;
    end
    return c;
  endfunction

  function automatic logic [VAL_W-1:0] low_bytes(input logic [VAL_W-1:0] v,
                                                  input logic [CODE_W-1:0] c);
    logic [VAL_W-1:0] r;
    unique case (c)
      CODE_1B: r = {56'd0, v[7:0]};
      CODE_2B: r = {48'd0, v[15:0]};
      CODE_4B: r = {32'd0, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic logic [BYTES_W-1:0] code_bytes(input logic [CODE_W-1:0] c);
    return BYTES_W'(1) << c;
  endfunction

endpackage

// ===== sv/rfse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rfse_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rfse_front.sv =====
// Front end: takes fields, picks size codes, stores fields and builds the record mask.
module rfse_front #(
  parameter int unsigned MaxFields = rfse_pkg::DEF_MAX_FIELDS,
  parameter int unsigned AddrW     = $clog2(2 * MaxFields)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [rfse_pkg::VAL_W-1:0]   field_value_i,
  input  logic                         last_field_i,
  output logic                         we_o,
  output logic [AddrW-1:0]             waddr_o,
  output logic [rfse_pkg::ENTRY_W-1:0] wdata_o,
  output logic                         push_o,
  output rfse_pkg::rec_t               rec_o
);
  import rfse_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             bank_q, bank_d;
  logic [VAL_W-1:0] mask_q, mask_d;
  logic [CODE_W-1:0] code;
  logic             has_room;
  logic [AddrW-1:0] base;

  assign code     = pick_code(field_value_i);
  assign has_room = count_q < CNT_W'(MaxFields);
  assign base     = bank_q ? AddrW'(MaxFields) : '0;

  assign we_o    = accept_i && has_room;
  assign waddr_o = base + AddrW'(count_q);
  assign wdata_o = {code, field_value_i};

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    mask_d  = mask_q;
    bank_d  = bank_q;
    push_o  = 1'b0;
    if (accept_i) begin
      if (has_room) begin
        count_d = count_q + CNT_W'(1);
        mask_d  = mask_q | (VAL_W'(code) << {count_q, 1'b0});
      end else begin
        ovf_d = 1'b1;
      end
    end
    rec_o.bank  = bank_q;
    rec_o.count = count_d;
    rec_o.trunc = ovf_d;
    rec_o.mask  = mask_d;
    if (accept_i && last_field_i) begin
      push_o  = 1'b1;
      count_d = '0;
      ovf_d   = 1'b0;
      mask_d  = '0;
      bank_d  = ~bank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      mask_q  <= '0;
      bank_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      mask_q  <= mask_d;
      bank_q  <= bank_d;
    end
  end

endmodule

// ===== sv/rfse_queue.sv =====
// Two-entry queue of finished record descriptors between front and back.
module rfse_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rfse_pkg::rec_t rec_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           nonempty_o,
  output rfse_pkg::rec_t head_o
);
  import rfse_pkg::*;

  rec_t       entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o     = fill_q == 2'd2;
  assign nonempty_o = fill_q != 2'd0;
  assign head_o     = entry_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    fill_d = fill_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

endmodule

// ===== sv/rfse_back.sv =====
// Back end: emits the mask chunk, then reads stored fields and emits one chunk each.
module rfse_back #(
  parameter int unsigned MaxFields = rfse_pkg::DEF_MAX_FIELDS,
  parameter int unsigned AddrW     = $clog2(2 * MaxFields)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         nonempty_i,
  input  rfse_pkg::rec_t               head_i,
  output logic                         pop_o,
  output logic                         re_o,
  output logic [AddrW-1:0]             raddr_o,
  input  logic [rfse_pkg::ENTRY_W-1:0] rdata_i,
  output logic                         valid_o,
  output logic [rfse_pkg::VAL_W-1:0]   chunk_data_o,
  output logic [rfse_pkg::BYTES_W-1:0] chunk_bytes_o,
  output logic                         is_mask_o,
  output logic                         truncated_o,
  output logic                         last_chunk_o
);
  import rfse_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_FIELDS = 1'b1;

  logic               state_q, state_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   idx_inc;
  logic [AddrW-1:0]   base;
  logic [CODE_W-1:0]  code;
  logic [CNT_W:0]     mbytes_sum;

  logic               valid_q, valid_d;
  logic [VAL_W-1:0]   data_q, data_d;
  logic [BYTES_W-1:0] bytes_q, bytes_d;
  logic               mask_q, mask_d;
  logic               trunc_q, trunc_d;
  logic               last_q, last_d;

  assign base       = head_i.bank ? AddrW'(MaxFields) : '0;
  assign code       = rdata_i[ENTRY_W-1:VAL_W];
  assign idx_inc    = idx_q + CNT_W'(1);
  assign mbytes_sum = ({1'b0, head_i.count} + (CNT_W+1)'(3)) >> 2;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    re_o    = 1'b0;
    raddr_o = base;
    valid_d = 1'b0;
    data_d  = data_q;
    bytes_d = bytes_q;
    mask_d  = mask_q;
    trunc_d = trunc_q;
    last_d  = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (nonempty_i) begin
          // mask chunk goes out while field 0 is fetched
          valid_d = 1'b1;
          data_d  = head_i.mask;
          bytes_d = BYTES_W'(mbytes_sum);
          mask_d  = 1'b1;
          trunc_d = head_i.trunc;
          last_d  = 1'b0;
          re_o    = 1'b1;
          idx_d   = '0;
          state_d = ST_FIELDS;
        end
      end
      default: begin
        valid_d = 1'b1;
        data_d  = low_bytes(rdata_i[VAL_W-1:0], code);
        bytes_d = code_bytes(code);
        mask_d  = 1'b0;
        trunc_d = head_i.trunc;
        last_d  = idx_inc == head_i.count;
        if (idx_inc == head_i.count) begin
          pop_o   = 1'b1;
          state_d = ST_IDLE;
        end else begin
          re_o    = 1'b1;
          raddr_o = base + AddrW'(idx_inc);
          idx_d   = idx_inc;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    bytes_q <= bytes_d;
    mask_q  <= mask_d;
    trunc_q <= trunc_d;
    last_q  <= last_d;
  end

  assign valid_o       = valid_q;
  assign chunk_data_o  = data_q;
  assign chunk_bytes_o = bytes_q;
  assign is_mask_o     = mask_q;
  assign truncated_o   = trunc_q;
  assign last_chunk_o  = last_q;

endmodule

// ===== sv/record_field_size_encoder_core.sv =====
// Top level of the record field size encoder: front end, record queue, field RAM, back end.
//
// One field is taken per cycle while busy_o is low. A record of n stored fields
// leaves as n+1 chunks (mask chunk first) on consecutive cycles, each shown for
// exactly one cycle with valid_o; the first chunk appears once the queue has
// registered the record's descriptor and the free back end has registered the
// mask chunk. The field RAM holds two banks of MAX_FIELDS entries, so one record
// can be filled while the previous one is emitted; busy_o rises while the queue
// holds two records (the one being emitted counts until its last chunk), so the
// sustained rate is set by the back end. Results cannot be stalled.
module record_field_size_encoder_core #(
  parameter int unsigned MAX_FIELDS = rfse_pkg::DEF_MAX_FIELDS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [rfse_pkg::VAL_W-1:0]   field_value_i,
  input  logic                         last_field_i,
  output logic                         valid_o,
  output logic [rfse_pkg::VAL_W-1:0]   chunk_data_o,
  output logic [rfse_pkg::BYTES_W-1:0] chunk_bytes_o,
  output logic                         is_mask_o,
  output logic                         truncated_o,
  output logic                         last_chunk_o
);
  import rfse_pkg::*;

  localparam int unsigned RamDepth = 2 * MAX_FIELDS;
  localparam int unsigned AddrW    = $clog2(RamDepth);

  logic               accept;
  logic               we;
  logic [AddrW-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;
  logic               re;
  logic [AddrW-1:0]   raddr;
  logic [ENTRY_W-1:0] rdata;
  logic               push;
  logic               pop;
  logic               full;
  logic               nonempty;
  rec_t               rec;
  rec_t               head;

  assign busy_o = full;
  assign accept = start_i && !full;

  rfse_front #(
    .MaxFields (MAX_FIELDS),
    .AddrW     (AddrW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .field_value_i (field_value_i),
    .last_field_i  (last_field_i),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .push_o        (push),
    .rec_o         (rec)
  );

  rfse_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rec_i      (rec),
    .pop_i      (pop),
    .full_o     (full),
    .nonempty_o (nonempty),
    .head_o     (head)
  );

  rfse_ram #(
    .Width (ENTRY_W),
    .Depth (RamDepth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  rfse_back #(
    .MaxFields (MAX_FIELDS),
    .AddrW     (AddrW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .nonempty_i    (nonempty),
    .head_i        (head),
    .pop_o         (pop),
    .re_o          (re),
    .raddr_o       (raddr),
    .rdata_i       (rdata),
    .valid_o       (valid_o),
    .chunk_data_o  (chunk_data_o),
    .chunk_bytes_o (chunk_bytes_o),
    .is_mask_o     (is_mask_o),
    .truncated_o   (truncated_o),
    .last_chunk_o  (last_chunk_o)
  );

endmodule
